/* rtl/core/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

/* rtl/core/mcpt_pkg.sv */
package mcpt_pkg;
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int DIM = 4;
	localparam int IO_BITS = 32;
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_CONCAT = 2'd1;
	localparam logic [1:0] OP_IDENT = 2'd2;
	localparam logic [1:0] OP_XFORM = 2'd3;

	typedef struct packed {
		logic       load_el;
		logic       ident;
		logic       clr_acc;
		logic       mac;
		logic       xform;
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
		logic       wr_nm;
		logic       commit;
		logic       cap_pt;
		logic       out_load;
	} cmd_t;
endpackage

/* rtl/core/matrix_concat_point_transform.sv */
// 4x4 Q16.16 transform unit with one shared multiply-accumulate. Load and
// identity requests complete in the accept state; a point transform runs accept,
// then 3 rows of 4 MACs plus a writeback each; a concatenation runs accept,
// 16 dot products of 4 MACs plus writeback, then a commit. The result
// shows on m_tvalid the cycle after the last writeback, and a held result stalls
// every new request. The single MAC sets rate.
module matrix_concat_point_transform #(
	parameter int FRAC_BITS = mcpt_pkg::FRAC_BITS,
	parameter int WORD_BITS = mcpt_pkg::WORD_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[1:0], row[3:2], col[5:4], element[37:6], point_x[69:38],
	// point_y[101:70], point_z[133:102], zero [135:134]
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], overflow[96], zero [103:97]
	output logic [103:0] m_tdata
);
	mcpt_pkg::cmd_t cmd;
	logic vld_q;
	logic signed [31:0] rx, ry, rz;
	logic rovf;

	mcpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_op(s_tdata[1:0]),
		.in_ready(s_tready), .out_busy(vld_q && !m_tready), .cmd(cmd)
	);

	mcpt_dp #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_row(s_tdata[3:2]),
		.in_col(s_tdata[5:4]), .in_element(s_tdata[37:6]), .in_px(s_tdata[69:38]),
		.in_py(s_tdata[101:70]), .in_pz(s_tdata[133:102]),
		.res_x(rx), .res_y(ry), .res_z(rz), .res_ovf(rovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (cmd.out_load) vld_q <= 1'b1;
		else if (m_tready) vld_q <= 1'b0;
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {7'd0, rovf, rz, ry, rx};
endmodule

/* rtl/core/mcpt_ctrl.sv */
module mcpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_op,
	output logic              in_ready,
	input  logic              out_busy,
	output mcpt_pkg::cmd_t    cmd
);
	typedef enum logic [2:0] {S_IDLE, S_CAT, S_CATWR, S_XF, S_XFWR, S_COMMIT} st_t;
	st_t st_q;
	logic [1:0] i_q, j_q, k_q;

	assign in_ready = (st_q == S_IDLE) && !out_busy;

	always_comb begin
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.k = k_q;
		case (st_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load_el = (in_op == mcpt_pkg::OP_LOAD);
					cmd.ident = (in_op == mcpt_pkg::OP_IDENT);
					cmd.cap_pt = (in_op == mcpt_pkg::OP_XFORM);
					cmd.clr_acc = 1'b1;
				end
			end
			S_CAT: cmd.mac = 1'b1;
			S_CATWR: begin
				cmd.wr_nm = 1'b1;
				cmd.clr_acc = 1'b1;
			end
			S_XF: begin
				cmd.mac = 1'b1;
				cmd.xform = 1'b1;
			end
			S_XFWR: begin
				cmd.wr_nm = 1'b1;
				cmd.xform = 1'b1;
				cmd.clr_acc = 1'b1;
				cmd.out_load = (i_q == 2'd2);
			end
			S_COMMIT: cmd.commit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					if (in_valid && in_ready) begin
						if (in_op == mcpt_pkg::OP_CONCAT) st_q <= S_CAT;
						else if (in_op == mcpt_pkg::OP_XFORM) st_q <= S_XF;
					end
				end
				S_CAT: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) st_q <= S_CATWR;
				end
				S_CATWR: begin
					{i_q, j_q} <= {i_q, j_q} + 4'd1;
					st_q <= ({i_q, j_q} == 4'hf) ? S_COMMIT : S_CAT;
				end
				S_XF: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) st_q <= S_XFWR;
				end
				S_XFWR: begin
					i_q <= i_q + 2'd1;
					st_q <= (i_q == 2'd2) ? S_IDLE : S_XF;
				end
				S_COMMIT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/mcpt_dp.sv */
module mcpt_dp #(
	parameter int FRAC_BITS = mcpt_pkg::FRAC_BITS,
	parameter int WORD_BITS = mcpt_pkg::WORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mcpt_pkg::cmd_t             cmd,
	input  logic [1:0]                 in_row,
	input  logic [1:0]                 in_col,
	input  logic signed [31:0]         in_element,
	input  logic signed [31:0]         in_px,
	input  logic signed [31:0]         in_py,
	input  logic signed [31:0]         in_pz,
	output logic signed [31:0]         res_x,
	output logic signed [31:0]         res_y,
	output logic signed [31:0]         res_z,
	output logic                       res_ovf
);
	localparam int W = WORD_BITS;
	localparam int PW = 2 * W;
	localparam int AW = PW + 3;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

	logic signed [W-1:0] cur_q [16];
	logic signed [W-1:0] nm_q [16];
	logic signed [W-1:0] ld_q [16];
	logic signed [W-1:0] pt_q [3];
	logic signed [W-1:0] rx_q, ry_q;
	logic signed [AW-1:0] acc_q;
	logic sticky_q;

	function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		if (e > 64'(WMAX)) return WMAX;
		if (e < 64'(WMIN)) return WMIN;
		return W'(e);
	endfunction
	function automatic logic sat_in_ovf(input logic signed [31:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return (e > 64'(WMAX)) || (e < 64'(WMIN));
	endfunction

	logic signed [W-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] sh, addend;
	logic signed [W-1:0] rsat;
	logic rovf;

	always_comb begin
		if (cmd.xform) begin
			ma = cur_q[{cmd.i, cmd.k}];
			mb = (cmd.k == 2'd3) ? ONE : pt_q[cmd.k];
		end else begin
			ma = ld_q[{cmd.i, cmd.k}];
			mb = cur_q[{cmd.k, cmd.j}];
		end
		prod = PW'(ma) * PW'(mb);
		addend = AW'(prod);
		sh = acc_q >>> FRAC_BITS;
		rovf = (sh > AW'(WMAX)) || (sh < AW'(WMIN));
		rsat = (sh > AW'(WMAX)) ? WMAX : (sh < AW'(WMIN)) ? WMIN : W'(sh);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) acc_q <= '0;
		else if (cmd.mac) acc_q <= acc_q + addend;
		if (cmd.cap_pt) begin
			pt_q[0] <= sat_in(in_px);
			pt_q[1] <= sat_in(in_py);
			pt_q[2] <= sat_in(in_pz);
		end
		if (cmd.wr_nm && !cmd.xform) nm_q[{cmd.i, cmd.j}] <= rsat;
		if (cmd.wr_nm && cmd.xform) begin
			if (cmd.i == 2'd0) rx_q <= rsat;
			if (cmd.i == 2'd1) ry_q <= rsat;
		end
		if (cmd.out_load) begin
			res_x <= 32'(rx_q);
			res_y <= 32'(ry_q);
			res_z <= 32'(rsat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= 1'b0;
			res_ovf <= 1'b0;
			for (int n = 0; n < 16; n++) begin
				cur_q[n] <= (n % 5 == 0) ? ONE : '0;
				ld_q[n] <= '0;
			end
		end else begin
			if (cmd.ident) begin
				sticky_q <= 1'b0;
				for (int n = 0; n < 16; n++) cur_q[n] <= (n % 5 == 0) ? ONE : '0;
			end else if (cmd.commit) begin
				for (int n = 0; n < 16; n++) cur_q[n] <= nm_q[n];
			end
			if (cmd.load_el) ld_q[{in_row, in_col}] <= sat_in(in_element);
			if (cmd.load_el && sat_in_ovf(in_element)) sticky_q <= 1'b1;
			if (cmd.cap_pt && (sat_in_ovf(in_px) || sat_in_ovf(in_py) ||
					sat_in_ovf(in_pz))) sticky_q <= 1'b1;
			if (cmd.wr_nm && rovf) sticky_q <= 1'b1;
			if (cmd.out_load) res_ovf <= sticky_q | rovf;
		end
	end
endmodule

/* rtl/core/mcpt_checker.sv */
`include "assert_macros.svh"
module mcpt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [135:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);
	`ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")
	`ASSERT_IMPL(a_pad, m_tvalid, m_tdata[103:97] == 7'd0, "pad bits set")
	`ASSERT_NEXT(a_busy, s_tvalid && s_tready && s_tdata[1:0] == mcpt_pkg::OP_XFORM, !s_tready,
		"accepted during transform")
	`ASSERT_NEXT(a_nores, s_tvalid && s_tready && s_tdata[1:0] != mcpt_pkg::OP_XFORM && !m_tvalid,
		!m_tvalid, "spurious result")
endmodule

bind matrix_concat_point_transform mcpt_checker u_chk (.*);

/* test/tb_top.sv */
module tb_top;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;

	always #6 clk = ~clk;

	matrix_concat_point_transform u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic        ovf;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} point_t;

	class xform_scoreboard;
		logic signed [31:0] cur [16];
		logic signed [31:0] ld [16];
		logic               sticky;
		point_t             pending_pts [$];
		int                 mismatches;
		int                 n_points;
		int                 n_concat;
		int                 n_sat;

		function new();
			for (int i = 0; i < 16; i++) begin
				cur[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
				ld[i] = 32'sd0;
			end
			sticky = 1'b0;
			mismatches = 0;
			n_points = 0;
			n_concat = 0;
			n_sat = 0;
		endfunction

		function logic signed [31:0] round_sat(logic signed [79:0] acc);
			logic signed [79:0] s;
			s = acc >>> mcpt_pkg::FRAC_BITS;
			if (s > 80'sd2147483647) begin
				sticky = 1'b1;
				return 32'sh7fffffff;
			end
			if (s < -80'sd2147483648) begin
				sticky = 1'b1;
				return 32'sh80000000;
			end
			return s[31:0];
		endfunction

		function logic signed [31:0] round_xrow(int i, logic signed [31:0] p [3]);
			logic signed [79:0] acc;
			acc = cur[i * 4 + 3];
			acc = acc <<< mcpt_pkg::FRAC_BITS;
			for (int k = 0; k < 3; k++)
				acc = acc + cur[i * 4 + k] * p[k];
			return round_sat(acc);
		endfunction

		function void note_request(logic [135:0] d);
			logic [1:0]         op;
			logic signed [31:0] nm [16];
			logic signed [31:0] p [3];
			logic signed [79:0] acc;
			point_t             e;
			op = d[1:0];
			case (op)
				mcpt_pkg::OP_LOAD: begin
					ld[{d[3:2], d[5:4]}] = d[37:6];
				end
				mcpt_pkg::OP_CONCAT: begin
					n_concat++;
					for (int i = 0; i < 4; i++)
						for (int j = 0; j < 4; j++) begin
							acc = '0;
							for (int k = 0; k < 4; k++)
								acc = acc + ld[i * 4 + k] * cur[k * 4 + j];
							nm[i * 4 + j] = round_sat(acc);
						end
					cur = nm;
				end
				mcpt_pkg::OP_IDENT: begin
					for (int i = 0; i < 16; i++)
						cur[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
					sticky = 1'b0;
				end
				default: begin
					p[0] = d[69:38];
					p[1] = d[101:70];
					p[2] = d[133:102];
					e.x = round_xrow(0, p);
					e.y = round_xrow(1, p);
					e.z = round_xrow(2, p);
					e.ovf = sticky;
					if (sticky) n_sat++;
					pending_pts.push_back(e);
				end
			endcase
		endfunction

		function void report(point_t e, point_t a, logic unexpected);
			mismatches++;
			if (mismatches <= 10) begin
				if (unexpected)
					$display("error: result with none pending x=%h y=%h z=%h ovf=%b",
						a.x, a.y, a.z, a.ovf);
				else
					$display("error: exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
						e.x, e.y, e.z, e.ovf, a.x, a.y, a.z, a.ovf);
			end
		endfunction

		function void check_result(logic [103:0] d);
			point_t e;
			point_t a;
			a = d[96:0];
			if (pending_pts.size() == 0) begin
				report('0, a, 1'b1);
				return;
			end
			e = pending_pts.pop_front();
			n_points++;
			if (a !== e || d[103:97] !== 7'd0) report(e, a, 1'b0);
		endfunction
	endclass

	xform_scoreboard sb = new();
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	bit quiet = 1'b0;

	// receiver: random backpressure (always ready while quiet) plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);
			end
		end
	end

	function logic [135:0] pack_req(logic [1:0] op, logic [1:0] row, logic [1:0] col,
			logic [31:0] el, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		return {2'b00, z, y, x, el, col, row, op};
	endfunction

	function logic [31:0] rand_val();
		int r;
		r = $urandom_range(9);
		if (r < 6) return $signed($urandom_range(262143)) - 32'sd131072;
		if (r < 8) return $signed($urandom_range(8388607)) - 32'sd4194304;
		return $urandom();
	endfunction

	task send_req(logic [135:0] d);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_request(d);
		if (!quiet && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task send_load(int row, int col, logic [31:0] el);
		send_req(pack_req(mcpt_pkg::OP_LOAD, 2'(row), 2'(col), el, $urandom(), $urandom(),
			$urandom()));
	endtask

	task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_req(pack_req(mcpt_pkg::OP_XFORM, 2'($urandom()), 2'($urandom()), $urandom(),
			x, y, z));
	endtask

	task send_op(logic [1:0] op);
		send_req(pack_req(op, 2'($urandom()), 2'($urandom()), $urandom(), $urandom(),
			$urandom(), $urandom()));
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending_pts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		int r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send_point(32'h7fffffff, 32'h80000000, 32'h0);
		send_point(32'h00010000, 32'hffff0000, 32'h00020000);
		send_load(0, 0, 32'h7fffffff);
		send_load(1, 1, 32'h80000000);
		send_load(2, 2, 32'h00010000);
		send_load(3, 3, 32'h00010000);
		send_load(0, 3, 32'h00050000);
		send_load(3, 0, 32'hffffffff);
		send_op(mcpt_pkg::OP_CONCAT);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_point(32'h0, 32'h0, 32'h0);
		send_op(mcpt_pkg::OP_IDENT);
		send_point(32'h00018000, 32'hfffe8000, 32'h00000001);
		for (int i = 0; i < 16; i++) send_load(i / 4, i % 4, (i % 5 == 0) ? 32'h10000 : 0);
		send_load(1, 3, 32'hfff00000);
		send_op(mcpt_pkg::OP_CONCAT);
		send_point(32'h80000000, 32'h1, 32'hffffffff);
		drain();
		// random
		for (int n = 0; n < 1650; n++) begin
			if (n == 400) quiet = 1'b1;
			if (n == 550) quiet = 1'b0;
			if (n == 800) hold_ticket++;
			if (n == 1100) drain();
			r = $urandom_range(99);
			if (r < 45) send_point(rand_val(), rand_val(), rand_val());
			else if (r < 88) send_load($urandom_range(3), $urandom_range(3), rand_val());
			else if (r < 96) send_op(mcpt_pkg::OP_CONCAT);
			else send_op(mcpt_pkg::OP_IDENT);
		end
		drain();
		$display("covered %0d point results, %0d concatenations, %0d with overflow set",
			sb.n_points, sb.n_concat, sb.n_sat);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_pts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#30000000;
		$display("simulation failed");
		$finish;
	end
endmodule
